### rtl/core/sbspr_pkg.sv
`timescale 1ns / 1ps
package sbspr_pkg;

  typedef enum logic [1:0] {
    REQ_ARM    = 2'd0,
    REQ_BYTE   = 2'd1,
    REQ_MIRROR = 2'd2,
    REQ_STATUS = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    RES_GOOD    = 2'd0,
    RES_CORRUPT = 2'd1,
    RES_MIRROR  = 2'd2,
    RES_STATUS  = 2'd3
  } res_t;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_HUNT1 = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_ERR   = 3'd4,
    PH_PARAM = 3'd5,
    PH_SUM   = 3'd6,
    PH_SKIP  = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MREAD,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_OUT
  } ctl_t;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] NO_REPLY_MARK = 8'hFF;

  typedef struct packed {
    res_t       kind;
    logic [7:0] id;
    logic [7:0] value;
    logic       no_reply;
  } result_t;

endpackage

### rtl/core/sbspr_parser.sv
`timescale 1ns / 1ps
module sbspr_parser #(
  parameter int MAX_PARAMS = 64,
  parameter int PW = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            rx_byte,
  output logic                  done,
  output logic                  good,
  output logic [7:0]            cur_id,
  output logic [7:0]            cur_error,
  output logic [7:0]            n_params,
  output logic                  pb_we,
  output logic [PW-1:0]         pb_waddr,
  output logic [7:0]            pb_wdata
);

  sbspr_pkg::phase_t phase, phase_next;
  logic [7:0] cur_length, running_sum, param_count;
  logic [7:0] sum_next;
  logic [7:0] err_reg;

  assign sum_next = running_sum + rx_byte;
  assign n_params = cur_length - 8'd2;
  assign pb_we    = take && (phase == sbspr_pkg::PH_PARAM);
  assign pb_waddr = param_count[PW-1:0];
  assign pb_wdata = rx_byte;
  assign cur_error = (phase == sbspr_pkg::PH_LEN) ? 8'd0 : err_reg;

  always_comb begin
    phase_next = phase;
    done = 1'b0;
    good = 1'b0;
    case (phase)
      sbspr_pkg::PH_HUNT:
        if (rx_byte == sbspr_pkg::SYNC_BYTE) phase_next = sbspr_pkg::PH_HUNT1;
      sbspr_pkg::PH_HUNT1:
        phase_next = (rx_byte == sbspr_pkg::SYNC_BYTE) ? sbspr_pkg::PH_ID : sbspr_pkg::PH_HUNT;
      sbspr_pkg::PH_ID: phase_next = sbspr_pkg::PH_LEN;
      sbspr_pkg::PH_LEN: begin
        if (rx_byte < 8'd2 || ({1'b0, rx_byte} - 9'd2) > 9'(MAX_PARAMS)) begin
          if (rx_byte == 8'd0) begin
            phase_next = sbspr_pkg::PH_HUNT;
            done = 1'b1;
          end else begin
            phase_next = sbspr_pkg::PH_SKIP;
          end
        end else begin
          phase_next = sbspr_pkg::PH_ERR;
        end
      end
      sbspr_pkg::PH_ERR:
        phase_next = (cur_length == 8'd2) ? sbspr_pkg::PH_SUM : sbspr_pkg::PH_PARAM;
      sbspr_pkg::PH_PARAM:
        if (param_count + 8'd1 >= n_params) phase_next = sbspr_pkg::PH_SUM;
      sbspr_pkg::PH_SUM: begin
        phase_next = sbspr_pkg::PH_HUNT;
        done = 1'b1;
        good = (~running_sum == rx_byte);
      end
      sbspr_pkg::PH_SKIP:
        if (param_count <= 8'd1) begin
          phase_next = sbspr_pkg::PH_HUNT;
          done = 1'b1;
        end
      default: phase_next = sbspr_pkg::PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sbspr_pkg::PH_HUNT;
      cur_id <= '0;
      cur_length <= '0;
      err_reg <= '0;
      running_sum <= '0;
      param_count <= '0;
    end else if (take) begin
      phase <= phase_next;
      case (phase)
        sbspr_pkg::PH_ID: begin
          cur_id <= rx_byte;
          running_sum <= rx_byte;
        end
        sbspr_pkg::PH_LEN: begin
          cur_length <= rx_byte;
          running_sum <= sum_next;
          err_reg <= '0;
          param_count <= (phase_next == sbspr_pkg::PH_SKIP) ? rx_byte : 8'd0;
        end
        sbspr_pkg::PH_ERR: begin
          err_reg <= rx_byte;
          running_sum <= sum_next;
        end
        sbspr_pkg::PH_PARAM: begin
          param_count <= param_count + 8'd1;
          running_sum <= sum_next;
        end
        sbspr_pkg::PH_SKIP:
          if (param_count != 8'd0) param_count <= param_count - 8'd1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/servo_bus_status_packet_receiver.sv
`timescale 1ns / 1ps
// Servo-bus status packet receiver.
// Input channel (in_valid/in_stall) carries requests: arm an id, one
// received bus byte, read a mirror byte, or read an id's status.
// Output channel (out_valid/out_stall) carries at most one result per
// request: packet good, packet corrupt, mirror data or id status.
// Requests are handled one at a time. Status reads and packet results
// are registered and appear in the cycle after acceptance. Mirror reads
// of a valid id go through a synchronous mirror read, then the output
// step, with the input stalled in both. A good packet's checksum byte
// (valid id, parameters present) starts a copy of the buffered
// parameters into the mirror, each read from the parameter buffer read
// port, then written; the input stalls until the copy is done.
// The output register holds a result until taken; while it is full and
// stalled, no request is accepted.
// Reset returns the parser to header hunting, clears start addresses and
// error bytes and sets every id's no-reply flag. Mirror and parameter
// buffer contents are not cleared and need no clearing pass.
module servo_bus_status_packet_receiver #(
  parameter int ID_COUNT = 32,
  parameter int MAX_PARAMS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] dev_id,
  input  logic [7:0] address,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] result_kind,
  output logic [7:0] pkt_id,
  output logic [7:0] value,
  output logic       no_reply
);

  localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int PW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int MD = ID_COUNT * 256;
  localparam int MW = $clog2(MD);

  sbspr_pkg::ctl_t state, state_next;
  sbspr_pkg::result_t res, res_next;
  logic res_load;

  logic [7:0] start_table [ID_COUNT];
  logic [7:0] error_table [ID_COUNT];
  logic [ID_COUNT-1:0] missing_flags;
  logic [7:0] mirror_store [MD];
  logic [7:0] param_buffer [MAX_PARAMS];

  logic accept, take, p_done, p_good;
  logic [7:0] p_id, p_err, p_n, pb_wdata;
  logic pb_we;
  logic [PW-1:0] pb_waddr;
  logic id_ok, pid_ok;
  logic [IW-1:0] idx, pidx;

  logic [7:0] copy_j, copy_n, copy_base, pb_rdata, mirror_rdata;
  logic [IW-1:0] copy_id;
  logic [7:0] q_id;
  logic q_ok;

  sbspr_pkg::req_t req;
  assign req = sbspr_pkg::req_t'(req_type);

  assign id_ok  = {24'd0, dev_id} < ID_COUNT;
  assign pid_ok = {24'd0, p_id} < ID_COUNT;
  assign idx  = dev_id[IW-1:0];
  assign pidx = p_id[IW-1:0];

  assign in_stall = (state != sbspr_pkg::ST_IDLE) || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;
  assign take = accept && (req == sbspr_pkg::REQ_BYTE);

  sbspr_parser #(.MAX_PARAMS(MAX_PARAMS), .PW(PW)) u_parser (
    .clk(clk), .rst(rst), .take(take), .rx_byte(rx_byte),
    .done(p_done), .good(p_good), .cur_id(p_id), .cur_error(p_err),
    .n_params(p_n), .pb_we(pb_we), .pb_waddr(pb_waddr), .pb_wdata(pb_wdata)
  );

  always_ff @(posedge clk) begin
    if (pb_we && {24'd0, p_n} > 0) param_buffer[pb_waddr] <= pb_wdata;
    pb_rdata <= param_buffer[copy_j[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == sbspr_pkg::ST_COPY_WR)
      mirror_store[MW'({copy_id, 8'(copy_base + copy_j)})] <= pb_rdata;
    if (accept) mirror_rdata <= mirror_store[MW'({idx, address})];
  end

  always_comb begin
    state_next = state;
    case (state)
      sbspr_pkg::ST_IDLE:
        if (accept) begin
          case (req)
            sbspr_pkg::REQ_BYTE:
              if (p_done && p_good && pid_ok && p_n != 8'd0) state_next = sbspr_pkg::ST_COPY_RD;
            sbspr_pkg::REQ_MIRROR:
              if (id_ok) state_next = sbspr_pkg::ST_MREAD;
            default: ;
          endcase
        end
      sbspr_pkg::ST_MREAD: state_next = sbspr_pkg::ST_OUT;
      sbspr_pkg::ST_COPY_RD: state_next = sbspr_pkg::ST_COPY_WR;
      sbspr_pkg::ST_COPY_WR:
        state_next = (copy_j + 8'd1 >= copy_n) ? sbspr_pkg::ST_IDLE : sbspr_pkg::ST_COPY_RD;
      sbspr_pkg::ST_OUT: state_next = sbspr_pkg::ST_IDLE;
      default: state_next = sbspr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    res_load = 1'b0;
    res_next = res;
    if (state == sbspr_pkg::ST_OUT) begin
      res_load = 1'b1;
      res_next = '{sbspr_pkg::RES_MIRROR, q_id, mirror_rdata, 1'b0};
    end else if (accept) begin
      case (req)
        sbspr_pkg::REQ_BYTE:
          if (p_done) begin
            res_load = 1'b1;
            res_next = '{p_good ? sbspr_pkg::RES_GOOD : sbspr_pkg::RES_CORRUPT, p_id,
                         p_err, 1'b0};
          end
        sbspr_pkg::REQ_MIRROR:
          if (!id_ok) begin
            res_load = 1'b1;
            res_next = '{sbspr_pkg::RES_MIRROR, dev_id, 8'd0, 1'b0};
          end
        sbspr_pkg::REQ_STATUS: begin
          res_load = 1'b1;
          res_next = id_ok ? sbspr_pkg::result_t'{sbspr_pkg::RES_STATUS, dev_id,
                                                  error_table[idx], missing_flags[idx]}
                           : sbspr_pkg::result_t'{sbspr_pkg::RES_STATUS, dev_id, 8'd0, 1'b1};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbspr_pkg::ST_IDLE;
      out_valid <= 1'b0;
      missing_flags <= '1;
      for (int i = 0; i < ID_COUNT; i++) begin
        start_table[i] <= '0;
        error_table[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (accept && req == sbspr_pkg::REQ_ARM && id_ok) begin
        start_table[idx] <= address;
        error_table[idx] <= sbspr_pkg::NO_REPLY_MARK;
        missing_flags[idx] <= 1'b1;
      end
      if (take && p_done && p_good && pid_ok) begin
        error_table[pidx] <= p_err;
        missing_flags[pidx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) res <= res_next;
    if (accept) begin
      q_id <= dev_id;
      q_ok <= id_ok;
    end
    if (accept && req == sbspr_pkg::REQ_BYTE) begin
      copy_j <= '0;
      copy_n <= p_n;
      copy_id <= pidx;
      copy_base <= start_table[pidx];
    end else if (state == sbspr_pkg::ST_COPY_WR) begin
      copy_j <= copy_j + 8'd1;
    end
  end

  assign result_kind = res.kind;
  assign pkt_id = res.id;
  assign value = res.value;
  assign no_reply = res.no_reply;

`ifndef SYNTHESIS
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != sbspr_pkg::ST_IDLE |-> in_stall) else $error("accept while busy");
  a_mread_out: assert property (@(posedge clk) disable iff (rst)
    state == sbspr_pkg::ST_MREAD |=> state == sbspr_pkg::ST_OUT && q_ok)
    else $error("mirror read sequence");
  a_copy_bound: assert property (@(posedge clk) disable iff (rst)
    state == sbspr_pkg::ST_COPY_WR |-> copy_j < copy_n) else $error("copy overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    state == sbspr_pkg::ST_OUT |-> !(out_valid && out_stall)) else $error("result lost");
`endif

endmodule

### tb/tb_servo_bus_status_packet_receiver.sv
`timescale 1ns / 1ps
module tb_servo_bus_status_packet_receiver;

  localparam int IDS = 32;
  localparam int MAXP = 64;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] req_type;
  logic [7:0] dev_id;
  logic [7:0] address;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] result_kind;
  logic [7:0] pkt_id;
  logic [7:0] value;
  logic       no_reply;

  servo_bus_status_packet_receiver dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .dev_id(dev_id), .address(address), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .result_kind(result_kind),
    .pkt_id(pkt_id), .value(value), .no_reply(no_reply)
  );

  // predictor state
  logic [7:0] mirror [IDS*256];
  bit         written [IDS*256];
  logic [7:0] arm_base [IDS];
  logic [7:0] err_byte [IDS];
  bit         missing [IDS];
  sbspr_pkg::phase_t phase;
  logic [7:0] p_id, p_len, p_err, p_sum, p_cnt;
  logic [7:0] p_buf [MAXP];

  sbspr_pkg::result_t expected_q[$];
  int         n_err;
  int         n_items;
  int         n_results;
  int         n_good;
  int         n_corrupt;
  bit         stall_off;
  int         hold_cnt;

  function automatic void push_result(sbspr_pkg::res_t k, logic [7:0] id, logic [7:0] v,
                                      logic nr);
    sbspr_pkg::result_t r;
    r.kind = k;
    r.id = id;
    r.value = v;
    r.no_reply = nr;
    expected_q.push_back(r);
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    case (phase)
      sbspr_pkg::PH_HUNT: if (b == sbspr_pkg::SYNC_BYTE) phase = sbspr_pkg::PH_HUNT1;
      sbspr_pkg::PH_HUNT1:
        phase = (b == sbspr_pkg::SYNC_BYTE) ? sbspr_pkg::PH_ID : sbspr_pkg::PH_HUNT;
      sbspr_pkg::PH_ID: begin
        p_id = b;
        p_sum = b;
        phase = sbspr_pkg::PH_LEN;
      end
      sbspr_pkg::PH_LEN: begin
        p_len = b;
        p_sum = p_sum + b;
        p_cnt = 8'd0;
        p_err = 8'd0;
        if (b < 2 || int'(b) - 2 > MAXP) begin
          if (b == 0) begin
            phase = sbspr_pkg::PH_HUNT;
            push_result(sbspr_pkg::RES_CORRUPT, p_id, 8'h00, 1'b0);
          end else begin
            p_cnt = b;
            phase = sbspr_pkg::PH_SKIP;
          end
        end else begin
          phase = sbspr_pkg::PH_ERR;
        end
      end
      sbspr_pkg::PH_ERR: begin
        p_err = b;
        p_sum = p_sum + b;
        phase = (p_len == 2) ? sbspr_pkg::PH_SUM : sbspr_pkg::PH_PARAM;
      end
      sbspr_pkg::PH_PARAM: begin
        if (p_cnt < MAXP) p_buf[p_cnt] = b;
        p_cnt = p_cnt + 8'd1;
        p_sum = p_sum + b;
        if (int'(p_cnt) >= int'(p_len) - 2) phase = sbspr_pkg::PH_SUM;
      end
      sbspr_pkg::PH_SUM: begin
        phase = sbspr_pkg::PH_HUNT;
        if (~p_sum != b) begin
          push_result(sbspr_pkg::RES_CORRUPT, p_id, p_err, 1'b0);
        end else begin
          if (p_id < IDS) begin
            for (int j = 0; j < int'(p_len) - 2; j++) begin
              int a;
              a = p_id * 256 + ((arm_base[p_id] + j) & 8'hFF);
              mirror[a] = p_buf[j];
              written[a] = 1;
            end
            err_byte[p_id] = p_err;
            missing[p_id] = 0;
          end
          push_result(sbspr_pkg::RES_GOOD, p_id, p_err, 1'b0);
        end
      end
      default: begin
        if (p_cnt > 0) p_cnt = p_cnt - 8'd1;
        if (p_cnt == 0) begin
          phase = sbspr_pkg::PH_HUNT;
          push_result(sbspr_pkg::RES_CORRUPT, p_id, 8'h00, 1'b0);
        end
      end
    endcase
  endfunction

  function automatic void predict_request(sbspr_pkg::req_t rq, logic [7:0] id,
                                          logic [7:0] ad, logic [7:0] b);
    case (rq)
      sbspr_pkg::REQ_ARM: if (id < IDS) begin
        arm_base[id] = ad;
        err_byte[id] = sbspr_pkg::NO_REPLY_MARK;
        missing[id] = 1;
      end
      sbspr_pkg::REQ_BYTE: predict_byte(b);
      sbspr_pkg::REQ_MIRROR:
        push_result(sbspr_pkg::RES_MIRROR, id, (id < IDS) ? mirror[id * 256 + ad] : 8'h00,
                    1'b0);
      default:
        if (id < IDS) push_result(sbspr_pkg::RES_STATUS, id, err_byte[id], missing[id]);
        else push_result(sbspr_pkg::RES_STATUS, id, 8'h00, 1'b1);
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #300ms;
    $display("servo_bus_status_packet_receiver regression: fail");
    $finish;
  end

  // result checker and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result kind=%0d id=%0d value=%0d",
                                    result_kind, pkt_id, value);
        end else begin
          sbspr_pkg::result_t e;
          e = expected_q.pop_front();
          if (result_kind != e.kind || pkt_id != e.id || value != e.value ||
              no_reply != e.no_reply) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch exp kind=%0d id=%0d value=%0d nr=%0d, got %0d %0d %0d %0d",
                       e.kind, e.id, e.value, e.no_reply,
                       result_kind, pkt_id, value, no_reply);
          end
          if (e.kind == sbspr_pkg::RES_GOOD) n_good++;
          if (e.kind == sbspr_pkg::RES_CORRUPT) n_corrupt++;
        end
        hold_cnt = stall_off ? 0 : int'($urandom_range(0, 4));
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end
      out_stall <= (hold_cnt != 0);
    end
  end

  task automatic send(sbspr_pkg::req_t rq, logic [7:0] id, logic [7:0] ad, logic [7:0] b);
    int gap;
    gap = stall_off ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    dev_id <= id;
    address <= ad;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(rq, id, ad, b);
    n_items++;
  endtask

  // send a whole packet; corrupt_sum flips one bit of the checksum
  task automatic send_packet(logic [7:0] id, logic [7:0] err, int np, bit corrupt_sum);
    logic [7:0] s;
    logic [7:0] prm;
    send(sbspr_pkg::REQ_BYTE, 8'($urandom), 8'($urandom), sbspr_pkg::SYNC_BYTE);
    send(sbspr_pkg::REQ_BYTE, 8'($urandom), 8'($urandom), sbspr_pkg::SYNC_BYTE);
    send(sbspr_pkg::REQ_BYTE, 8'($urandom), 8'($urandom), id);
    send(sbspr_pkg::REQ_BYTE, 8'($urandom), 8'($urandom), 8'(np + 2));
    send(sbspr_pkg::REQ_BYTE, 8'($urandom), 8'($urandom), err);
    s = id + 8'(np + 2) + err;
    for (int i = 0; i < np; i++) begin
      prm = 8'($urandom);
      s = s + prm;
      send(sbspr_pkg::REQ_BYTE, 8'($urandom), 8'($urandom), prm);
    end
    send(sbspr_pkg::REQ_BYTE, 8'($urandom), 8'($urandom),
         corrupt_sum ? ~s ^ 8'(1 << $urandom_range(0, 7)) : ~s);
  endtask

  // read one mirror byte that was written (any byte for an out-of-range id)
  task automatic read_written(logic [7:0] id);
    logic [7:0] ad;
    if (id >= IDS) begin
      send(sbspr_pkg::REQ_MIRROR, id, 8'($urandom), 8'($urandom));
      return;
    end
    ad = 8'($urandom);
    for (int k = 0; k < 256; k++) begin
      if (written[id * 256 + ad]) begin
        send(sbspr_pkg::REQ_MIRROR, id, ad, 8'($urandom));
        return;
      end
      ad++;
    end
  endtask

  task automatic test_directed();
    send(sbspr_pkg::REQ_STATUS, 8'd0, 8'd0, 8'd0);
    send(sbspr_pkg::REQ_STATUS, 8'd255, 8'd255, 8'd255);
    send(sbspr_pkg::REQ_ARM, 8'd31, 8'd250, 8'd0);
    send(sbspr_pkg::REQ_STATUS, 8'd31, 8'd0, 8'd0);
    send_packet(8'd31, 8'h00, 10, 0);
    send(sbspr_pkg::REQ_MIRROR, 8'd31, 8'd255, 8'd0);
    send(sbspr_pkg::REQ_MIRROR, 8'd31, 8'd3, 8'd0);
    send(sbspr_pkg::REQ_STATUS, 8'd31, 8'd0, 8'd0);
    send_packet(8'd0, 8'hAA, 0, 0);
    send_packet(8'd5, 8'h55, 3, 1);
    send(sbspr_pkg::REQ_ARM, 8'd200, 8'd7, 8'd0);
    send_packet(8'd200, 8'hFF, 64, 0);
    send(sbspr_pkg::REQ_MIRROR, 8'd200, 8'd7, 8'd0);
    send(sbspr_pkg::REQ_STATUS, 8'd200, 8'd0, 8'd0);
  endtask

  task automatic test_bad_lengths();
    send(sbspr_pkg::REQ_BYTE, 8'd0, 8'd0, sbspr_pkg::SYNC_BYTE);
    send(sbspr_pkg::REQ_BYTE, 8'd0, 8'd0, sbspr_pkg::SYNC_BYTE);
    send(sbspr_pkg::REQ_BYTE, 8'd0, 8'd0, sbspr_pkg::SYNC_BYTE);
    send(sbspr_pkg::REQ_BYTE, 8'd0, 8'd0, 8'd0);
    for (int l = 0; l < 3; l++) begin
      logic [7:0] ln;
      ln = (l == 0) ? 8'd1 : (l == 1) ? 8'd67 : 8'd255;
      send(sbspr_pkg::REQ_BYTE, 8'd0, 8'd0, sbspr_pkg::SYNC_BYTE);
      send(sbspr_pkg::REQ_BYTE, 8'd0, 8'd0, sbspr_pkg::SYNC_BYTE);
      send(sbspr_pkg::REQ_BYTE, 8'd0, 8'd0, 8'd9);
      send(sbspr_pkg::REQ_BYTE, 8'd0, 8'd0, ln);
      for (int i = 0; i < ln; i++) send(sbspr_pkg::REQ_BYTE, 8'd0, 8'd0, 8'($urandom));
    end
    send(sbspr_pkg::REQ_BYTE, 8'd0, 8'd0, sbspr_pkg::SYNC_BYTE);
    send(sbspr_pkg::REQ_BYTE, 8'd0, 8'd0, 8'h12);
  endtask

  task automatic test_random(int count);
    int start;
    start = n_items;
    while (n_items - start < count) begin
      int pick;
      logic [7:0] id;
      pick = $urandom_range(0, 99);
      id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, IDS - 1));
      stall_off = ($urandom_range(0, 9) == 0);
      if (pick < 45) begin
        send_packet(id, 8'($urandom), ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64)
                                                                  : $urandom_range(0, 8),
                    $urandom_range(0, 4) == 0);
      end else if (pick < 55) begin
        send(sbspr_pkg::REQ_ARM, id, 8'($urandom), 8'($urandom));
      end else if (pick < 70) begin
        read_written(id);
      end else if (pick < 80) begin
        send(sbspr_pkg::REQ_STATUS, id, 8'($urandom), 8'($urandom));
      end else begin
        send(sbspr_pkg::REQ_BYTE, 8'($urandom), 8'($urandom),
             ($urandom_range(0, 2) == 0) ? sbspr_pkg::SYNC_BYTE : 8'($urandom));
      end
    end
    stall_off = 0;
  endtask

  initial begin
    int waited;
    rst = 1;
    in_valid = 0;
    req_type = sbspr_pkg::REQ_ARM;
    dev_id = 0;
    address = 0;
    rx_byte = 0;
    stall_off = 0;
    n_err = 0;
    n_items = 0;
    n_results = 0;
    n_good = 0;
    n_corrupt = 0;
    phase = sbspr_pkg::PH_HUNT;
    p_id = 0; p_len = 0; p_err = 0; p_sum = 0; p_cnt = 0;
    foreach (arm_base[i]) begin
      arm_base[i] = 0;
      err_byte[i] = 0;
      missing[i] = 1;
    end
    foreach (written[i]) begin
      written[i] = 0;
      mirror[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    test_directed();
    test_bad_lengths();
    test_random(1300);
    in_valid <= 1'b0;

    waited = 0;
    while (expected_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    $display("%0d requests sent, %0d results checked (%0d good packets, %0d corrupt)",
             n_items, n_results, n_good, n_corrupt);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("servo_bus_status_packet_receiver regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", n_err, expected_q.size());
      $display("servo_bus_status_packet_receiver regression: fail");
    end
    $finish;
  end

endmodule

### servo_bus_status_packet_receiver.f
rtl/core/sbspr_pkg.sv
rtl/core/sbspr_parser.sv
rtl/core/servo_bus_status_packet_receiver.sv
tb/tb_servo_bus_status_packet_receiver.sv
